FILE: sv/text_console_cursor_engine_defines.svh
// Assertion macros for the text console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

`ifndef SYNTH
`define TCCE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcce assertion failed");
`define TCCE_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tcce assertion failed");
`else
`define TCCE_ASSERT(lbl, clk, rst_n, prop)
`define TCCE_ASSERT_NR(lbl, clk, prop)
`endif

`endif

FILE: sv/tcce_pkg.sv
// Shared types and constants for the text console cursor engine.
`timescale 1ns / 1ps
package tcce_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam logic [7:0] BLANK_CHAR      = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR    = 8'h0A;
    localparam logic [7:0] RESET_COLOR     = 8'h07;
    localparam logic [7:0] CELL_COLOR_MASK = 8'h0F;

    typedef enum logic [3:0] {
        KIND_PUT         = 4'd0,
        KIND_MOVE        = 4'd1,
        KIND_LEFT        = 4'd2,
        KIND_RIGHT       = 4'd3,
        KIND_DELETE      = 4'd4,
        KIND_CLEAR_LINE  = 4'd5,
        KIND_CLEAR_SCRN  = 4'd6,
        KIND_WRITE       = 4'd7,
        KIND_READ        = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_FILL_LINE,
        ST_FILL_SCREEN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] char_code;
        logic [4:0] target_row;
        logic [6:0] target_column;
        logic [3:0] cell_color;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
    } out_item_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

FILE: sv/tcce_screen_ram.sv
// Screen cell memory with a single address: one write and one registered read per cycle.
`timescale 1ns / 1ps
module tcce_screen_ram #(
    parameter int CELLS = tcce_pkg::DEFAULT_COLUMNS * tcce_pkg::DEFAULT_ROWS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic                 aclk,
    input  tcce_pkg::ram_ctl_t   ctl,
    input  logic [ADDR_W-1:0]    addr,
    input  logic [15:0]          wr_data,
    output logic [15:0]          rd_data
);

    logic [15:0] mem [CELLS];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/text_console_cursor_engine.sv
// Text console cursor engine top level: command sequencer, cursor and screen memory.
//
//  channel | ports                      | transfer
//  --------+----------------------------+--------------------------------
//  input   | s_valid s_ready s_data     | one command
//  result  | m_valid m_ready m_data     | cursor and read data per command
//  config  | cfg_wr_en cfg_wr_data      | text_color write, no wait
//
// Put, newline, move, step, write cell, read cell: EXEC, then DONE registers the
// result, then IDLE takes the next command. Delete shifts the row left through
// DEL_RD and DEL_WR and blanks the last cell; clear line and clear screen write
// one cell per cycle through the single memory port. After reset an INIT pass
// blanks the screen before s_ready rises. A stalled result register holds DONE.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_defines.svh"
module text_console_cursor_engine #(
    parameter int SCREEN_COLUMNS = tcce_pkg::DEFAULT_COLUMNS,
    parameter int SCREEN_ROWS    = tcce_pkg::DEFAULT_ROWS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcce_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tcce_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

    tcce_pkg::state_t    state_reg, state_next;
    tcce_pkg::in_item_t  cmd_reg, cmd_next;
    tcce_pkg::out_item_t m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [COL_W-1:0]    col_cnt_reg, col_cnt_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]          color_reg;
    logic                hit_reg, hit_next;

    // shared address unit
    logic [ROW_W-1:0]    au_row;
    logic [COL_W-1:0]    au_col;
    logic [ADDR_W-1:0]   au_addr;
    logic [31:0]         pos_full;

    tcce_pkg::ram_ctl_t  ram_ctl;
    logic [ADDR_W-1:0]   ram_addr;
    logic [15:0]         ram_wdata;
    logic [15:0]         ram_rdata;

    logic                in_range;
    logic [ROW_W-1:0]    row_inc;
    logic [15:0]         blank;
    logic                out_load;

    assign in_range = (32'(cmd_reg.target_row) < SCREEN_ROWS)
                   && (32'(cmd_reg.target_column) < SCREEN_COLUMNS);
    assign row_inc  = (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
    assign blank    = {color_reg, tcce_pkg::BLANK_CHAR};
    assign out_load = (state_reg == tcce_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    assign pos_full = 32'(au_row) * SCREEN_COLUMNS + 32'(au_col);
    assign au_addr  = pos_full[ADDR_W-1:0];

    tcce_screen_ram #(
        .CELLS (CELLS)
    ) u_ram (
        .aclk    (aclk),
        .ctl     (ram_ctl),
        .addr    (ram_addr),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcce_pkg::ST_INIT;
            m_valid_reg <= 1'b0;
            row_reg     <= '0;
            col_reg     <= '0;
            cnt_reg     <= '0;
            color_reg   <= tcce_pkg::RESET_COLOR;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            cnt_reg     <= cnt_next;
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        m_data_reg  <= m_data_next;
        col_cnt_reg <= col_cnt_next;
        hit_reg     <= hit_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcce_pkg::ST_INIT: begin
                if (cnt_reg == CELL_LAST) begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tcce_pkg::ST_EXEC;
                end
            end
            tcce_pkg::ST_EXEC: begin
                unique case (cmd_reg.kind)
                    tcce_pkg::KIND_DELETE:     state_next = tcce_pkg::ST_DEL_RD;
                    tcce_pkg::KIND_CLEAR_LINE: state_next = tcce_pkg::ST_FILL_LINE;
                    tcce_pkg::KIND_CLEAR_SCRN: state_next = tcce_pkg::ST_FILL_SCREEN;
                    default:                   state_next = tcce_pkg::ST_DONE;
                endcase
            end
            tcce_pkg::ST_DEL_RD: begin
                state_next = (col_cnt_reg == COL_LAST) ? tcce_pkg::ST_DONE
                                                       : tcce_pkg::ST_DEL_WR;
            end
            tcce_pkg::ST_DEL_WR: begin
                state_next = tcce_pkg::ST_DEL_RD;
            end
            tcce_pkg::ST_FILL_LINE: begin
                if (col_cnt_reg == COL_LAST) begin
                    state_next = tcce_pkg::ST_DONE;
                end
            end
            tcce_pkg::ST_FILL_SCREEN: begin
                if (cnt_reg == CELL_LAST) begin
                    state_next = tcce_pkg::ST_DONE;
                end
            end
            tcce_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            default: state_next = tcce_pkg::ST_INIT;
        endcase
    end

    // datapath and memory control
    always_comb begin
        s_ready      = 1'b0;
        cmd_next     = cmd_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        col_cnt_next = col_cnt_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        au_row       = row_reg;
        au_col       = col_reg;
        ram_ctl      = '0;
        ram_addr     = au_addr;
        ram_wdata    = blank;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            tcce_pkg::ST_INIT: begin
                ram_ctl.wr_en = 1'b1;
                ram_addr      = cnt_reg;
                ram_wdata     = {tcce_pkg::RESET_COLOR, tcce_pkg::BLANK_CHAR};
                cnt_next      = cnt_reg + ADDR_W'(1);
            end
            tcce_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd_next = s_data;
            end
            tcce_pkg::ST_EXEC: begin
                hit_next = 1'b0;
                unique case (cmd_reg.kind)
                    tcce_pkg::KIND_PUT: begin
                        if (cmd_reg.char_code == tcce_pkg::NEWLINE_CHAR) begin
                            col_next = '0;
                            row_next = row_inc;
                        end else begin
                            ram_ctl.wr_en = 1'b1;
                            ram_wdata     = {color_reg, cmd_reg.char_code};
                            if (col_reg == COL_LAST) begin
                                col_next = '0;
                                row_next = row_inc;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                    end
                    tcce_pkg::KIND_MOVE: begin
                        if (in_range) begin
                            row_next = cmd_reg.target_row[ROW_W-1:0];
                            col_next = cmd_reg.target_column[COL_W-1:0];
                        end
                    end
                    tcce_pkg::KIND_LEFT: begin
                        if (col_reg != '0) begin
                            col_next = col_reg - COL_W'(1);
                        end else if (row_reg != '0) begin
                            row_next = row_reg - ROW_W'(1);
                            col_next = COL_LAST;
                        end
                    end
                    tcce_pkg::KIND_RIGHT: begin
                        if (col_reg != COL_LAST) begin
                            col_next = col_reg + COL_W'(1);
                        end else if (row_reg != ROW_LAST) begin
                            row_next = row_reg + ROW_W'(1);
                            col_next = '0;
                        end
                    end
                    tcce_pkg::KIND_DELETE: begin
                        col_cnt_next = col_reg;
                    end
                    tcce_pkg::KIND_CLEAR_LINE: begin
                        col_cnt_next = '0;
                    end
                    tcce_pkg::KIND_CLEAR_SCRN: begin
                        cnt_next = '0;
                    end
                    tcce_pkg::KIND_WRITE: begin
                        au_row        = cmd_reg.target_row[ROW_W-1:0];
                        au_col        = cmd_reg.target_column[COL_W-1:0];
                        ram_ctl.wr_en = in_range;
                        ram_wdata     = {tcce_pkg::CELL_COLOR_MASK & {4'h0, cmd_reg.cell_color},
                                         cmd_reg.char_code};
                    end
                    tcce_pkg::KIND_READ: begin
                        au_row        = cmd_reg.target_row[ROW_W-1:0];
                        au_col        = cmd_reg.target_column[COL_W-1:0];
                        ram_ctl.rd_en = in_range;
                        hit_next      = in_range;
                    end
                    default: ;
                endcase
            end
            tcce_pkg::ST_DEL_RD: begin
                if (col_cnt_reg == COL_LAST) begin
                    au_col        = col_cnt_reg;
                    ram_ctl.wr_en = 1'b1;
                end else begin
                    au_col        = col_cnt_reg + COL_W'(1);
                    ram_ctl.rd_en = 1'b1;
                end
            end
            tcce_pkg::ST_DEL_WR: begin
                au_col        = col_cnt_reg;
                ram_ctl.wr_en = 1'b1;
                ram_wdata     = ram_rdata;
                col_cnt_next  = col_cnt_reg + COL_W'(1);
            end
            tcce_pkg::ST_FILL_LINE: begin
                au_col        = col_cnt_reg;
                ram_ctl.wr_en = 1'b1;
                col_cnt_next  = col_cnt_reg + COL_W'(1);
                if (col_cnt_reg == COL_LAST) begin
                    col_next = '0;
                end
            end
            tcce_pkg::ST_FILL_SCREEN: begin
                ram_ctl.wr_en = 1'b1;
                ram_addr      = cnt_reg;
                cnt_next      = cnt_reg + ADDR_W'(1);
                if (cnt_reg == CELL_LAST) begin
                    row_next = '0;
                    col_next = '0;
                end
            end
            tcce_pkg::ST_DONE: begin
                if (out_load) begin
                    m_valid_next                = 1'b1;
                    m_data_next.cursor_row      = 5'(row_reg);
                    m_data_next.cursor_column   = 7'(col_reg);
                    m_data_next.cursor_position = pos_full[10:0];
                    m_data_next.cell_data       =
                        (cmd_reg.kind == tcce_pkg::KIND_READ && hit_reg) ? ram_rdata : 16'h0;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `TCCE_ASSERT(a_accept_exec, aclk, aresetn, s_valid && s_ready |=> state_reg == tcce_pkg::ST_EXEC)
    `TCCE_ASSERT(a_cursor_range, aclk, aresetn, row_reg <= ROW_LAST && col_reg <= COL_LAST)
    `TCCE_ASSERT(a_done_load, aclk, aresetn, out_load |=> m_valid_reg && state_reg == tcce_pkg::ST_IDLE)
    `TCCE_ASSERT_NR(a_ram_port, aclk, !(ram_ctl.wr_en && ram_ctl.rd_en))

endmodule

FILE: bench/tb.sv
// Self-checking testbench for text_console_cursor_engine: directed and random command traffic.
`timescale 1ns / 1ps
module tb;

    localparam int COLS          = tcce_pkg::DEFAULT_COLUMNS;
    localparam int ROWS          = tcce_pkg::DEFAULT_ROWS;
    localparam int CELLS         = ROWS * COLS;
    localparam int PHASES        = 5;
    localparam int RANDOM_ITEMS  = 1125;
    localparam int KIND_CODE_TOP = 15;
    localparam int ROW_CODE_TOP  = 31;
    localparam int COL_CODE_TOP  = 127;
    localparam int MAX_GAP       = 60;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE        = 8;
    localparam int DRAIN         = CELLS + 16;
    localparam int MAX_REPORTS   = 10;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    tcce_pkg::in_item_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    tcce_pkg::out_item_t m_data;
    logic                cfg_wr_en   = 1'b0;
    logic [7:0]          cfg_wr_data = '0;
    logic                long_hold   = 1'b0;

    // shadow of the screen, cursor and text color
    logic [15:0] shadow_screen [CELLS];
    logic [4:0]  shadow_row;
    logic [6:0]  shadow_col;
    logic [7:0]  shadow_color;

    tcce_pkg::in_item_t  command_q [$];
    tcce_pkg::out_item_t cursor_report_q [$];

    int     tx_gap = 0;
    int     tx_calm = 0;
    int     rx_gap = 0;
    int     rx_calm = 0;
    int     accepted = 0;
    int     checked = 0;
    int     mismatches = 0;
    longint cycles = 0;
    longint cycle_budget = 0;

    text_console_cursor_engine u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [15:0] blank_cell();
        return {shadow_color, tcce_pkg::BLANK_CHAR};
    endfunction

    function automatic tcce_pkg::out_item_t console_apply(tcce_pkg::in_item_t cmd);
        tcce_pkg::out_item_t res;
        int        base;
        int        x;
        int        pos;
        bit        hit;
        res  = '0;
        hit  = (cmd.target_row < ROWS) && (cmd.target_column < COLS);
        base = int'(shadow_row) * COLS;
        case (cmd.kind)
            tcce_pkg::KIND_PUT: begin
                if (cmd.char_code == tcce_pkg::NEWLINE_CHAR) begin
                    shadow_col = '0;
                    shadow_row = (shadow_row == ROWS - 1) ? '0 : shadow_row + 1'b1;
                end else begin
                    shadow_screen[base + shadow_col] = {shadow_color, cmd.char_code};
                    if (shadow_col == COLS - 1) begin
                        shadow_col = '0;
                        shadow_row = (shadow_row == ROWS - 1) ? '0 : shadow_row + 1'b1;
                    end else begin
                        shadow_col = shadow_col + 1'b1;
                    end
                end
            end
            tcce_pkg::KIND_MOVE: begin
                if (hit) begin
                    shadow_row = cmd.target_row;
                    shadow_col = cmd.target_column;
                end
            end
            tcce_pkg::KIND_LEFT: begin
                if (shadow_col > 0) begin
                    shadow_col = shadow_col - 1'b1;
                end else if (shadow_row > 0) begin
                    shadow_row = shadow_row - 1'b1;
                    shadow_col = 7'(COLS - 1);
                end
            end
            tcce_pkg::KIND_RIGHT: begin
                if (shadow_col < COLS - 1) begin
                    shadow_col = shadow_col + 1'b1;
                end else if (shadow_row < ROWS - 1) begin
                    shadow_row = shadow_row + 1'b1;
                    shadow_col = '0;
                end
            end
            tcce_pkg::KIND_DELETE: begin
                for (x = shadow_col; x < COLS - 1; x++)
                    shadow_screen[base + x] = shadow_screen[base + x + 1];
                shadow_screen[base + COLS - 1] = blank_cell();
            end
            tcce_pkg::KIND_CLEAR_LINE: begin
                for (x = 0; x < COLS; x++)
                    shadow_screen[base + x] = blank_cell();
                shadow_col = '0;
            end
            tcce_pkg::KIND_CLEAR_SCRN: begin
                for (x = 0; x < CELLS; x++)
                    shadow_screen[x] = blank_cell();
                shadow_row = '0;
                shadow_col = '0;
            end
            tcce_pkg::KIND_WRITE: begin
                if (hit)
                    shadow_screen[int'(cmd.target_row) * COLS + cmd.target_column] =
                        {tcce_pkg::CELL_COLOR_MASK & 8'(cmd.cell_color), cmd.char_code};
            end
            tcce_pkg::KIND_READ: begin
                if (hit)
                    res.cell_data = shadow_screen[int'(cmd.target_row) * COLS + cmd.target_column];
            end
            default: ;
        endcase
        pos                 = int'(shadow_row) * COLS + shadow_col;
        res.cursor_row      = shadow_row;
        res.cursor_column   = shadow_col;
        res.cursor_position = pos[10:0];
        return res;
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, MAX_GAP);
    endfunction

    function automatic tcce_pkg::in_item_t make_cmd(logic [3:0] k, logic [7:0] ch, int row,
                                                    int col, logic [3:0] color);
        tcce_pkg::in_item_t c;
        c.kind          = k;
        c.char_code     = ch;
        c.target_row    = row[4:0];
        c.target_column = col[6:0];
        c.cell_color    = color;
        return c;
    endfunction

    function automatic int pick_row(bit legal);
        int r;
        if (!legal) return $urandom_range(ROWS, ROW_CODE_TOP);
        r = $urandom_range(0, 9);
        if (r < 2) return 0;
        if (r < 4) return ROWS - 1;
        if (r < 7) return $urandom_range(0, 3);
        return $urandom_range(0, ROWS - 1);
    endfunction

    function automatic int pick_col(bit legal);
        int r;
        if (!legal) return $urandom_range(COLS, COL_CODE_TOP);
        r = $urandom_range(0, 9);
        if (r < 2) return 0;
        if (r < 4) return COLS - 1;
        if (r < 6) return $urandom_range(0, 7);
        return $urandom_range(0, COLS - 1);
    endfunction

    function automatic tcce_pkg::in_item_t random_cmd();
        int         r;
        bit         bad;
        bit         bad_row;
        bit         bad_col;
        int         trow;
        int         tcol;
        logic [7:0] ch;
        logic [3:0] color;
        logic [3:0] k;
        r       = $urandom_range(0, 99);
        bad     = $urandom_range(0, 99) < 15;
        bad_row = bad && $urandom_range(0, 1);
        bad_col = bad && (!bad_row || $urandom_range(0, 1));
        trow    = pick_row(!bad_row);
        tcol    = pick_col(!bad_col);
        ch      = 8'($urandom_range(0, 255));
        color   = 4'($urandom_range(0, 15));
        if (r < 36) begin
            k = tcce_pkg::KIND_PUT;
            if ($urandom_range(0, 9) == 0) ch = tcce_pkg::NEWLINE_CHAR;
        end else if (r < 48) k = tcce_pkg::KIND_MOVE;
        else if (r < 56) k = tcce_pkg::KIND_LEFT;
        else if (r < 64) k = tcce_pkg::KIND_RIGHT;
        else if (r < 72) k = tcce_pkg::KIND_DELETE;
        else if (r < 76) k = tcce_pkg::KIND_CLEAR_LINE;
        else if (r < 77) k = tcce_pkg::KIND_CLEAR_SCRN;
        else if (r < 87) k = tcce_pkg::KIND_WRITE;
        else if (r < 99) k = tcce_pkg::KIND_READ;
        else k = 4'($urandom_range(int'(tcce_pkg::KIND_READ) + 1, KIND_CODE_TOP));
        return make_cmd(k, ch, trow, tcol, color);
    endfunction

    task automatic queue_cmd(tcce_pkg::in_item_t c);
        int cost;
        case (c.kind)
            tcce_pkg::KIND_CLEAR_SCRN: cost = CELLS + 4;
            tcce_pkg::KIND_DELETE:     cost = 2 * COLS + 4;
            tcce_pkg::KIND_CLEAR_LINE: cost = COLS + 4;
            default:                   cost = 4;
        endcase
        command_q.push_back(c);
        cycle_budget += cost + 2 * MAX_GAP;
    endtask

    task automatic wait_idle(int extra);
        while (command_q.size() > 0 || s_valid || cursor_report_q.size() > 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic report_field(string name, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    endtask

    task automatic check_result(tcce_pkg::out_item_t got);
        tcce_pkg::out_item_t want;
        checked++;
        if (cursor_report_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] result transfer with nothing pending: %p", $realtime, got);
            return;
        end
        want = cursor_report_q.pop_front();
        if (got.cursor_row !== want.cursor_row)
            report_field("cursor_row", want.cursor_row, got.cursor_row);
        if (got.cursor_column !== want.cursor_column)
            report_field("cursor_column", want.cursor_column, got.cursor_column);
        if (got.cursor_position !== want.cursor_position)
            report_field("cursor_position", want.cursor_position, got.cursor_position);
        if (got.cell_data !== want.cell_data)
            report_field("cell_data", want.cell_data, got.cell_data);
    endtask

    // command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                cursor_report_q.push_back(console_apply(s_data));
                accepted++;
            end
            if (s_valid && !s_ready) begin
                // hold the offered command
            end else if (tx_gap > 0) begin
                tx_gap  <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (command_q.size() > 0) begin
                s_data  <= command_q.pop_front();
                s_valid <= 1'b1;
                tx_gap  <= pick_gap(tx_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
                rx_gap = pick_gap(rx_calm);
            end
            if (long_hold) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // long result hold-off so the engine backs up into its input
    initial begin
        do @(posedge aclk); while (!(accepted >= 300 && command_q.size() > 100));
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 4 * cycle_budget + CELLS + HOLD_CYCLES + 20000) begin
            $display("text_console_cursor_engine regression: fail");
            $finish;
        end
    end

    initial begin
        int                 count;
        int                 phase;
        int                 i;
        tcce_pkg::in_item_t c;
        logic [7:0]         phase_color [PHASES];

        phase_color[0] = tcce_pkg::RESET_COLOR;
        phase_color[1] = 8'h00;
        phase_color[2] = 8'hFF;
        phase_color[3] = 8'($urandom_range(0, 255));
        phase_color[4] = 8'hA5;

        shadow_color = tcce_pkg::RESET_COLOR;
        for (i = 0; i < CELLS; i++)
            shadow_screen[i] = blank_cell();
        shadow_row = '0;
        shadow_col = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        queue_cmd(make_cmd(tcce_pkg::KIND_READ, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_PUT, 8'h41, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_PUT, 8'hFF, ROW_CODE_TOP, COL_CODE_TOP, 4'hF));
        queue_cmd(make_cmd(tcce_pkg::KIND_PUT, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_PUT, tcce_pkg::NEWLINE_CHAR, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_LEFT, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_RIGHT, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_MOVE, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_LEFT, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_MOVE, 8'h00, ROWS - 1, COLS - 1, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_RIGHT, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_PUT, 8'h5A, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_MOVE, 8'h00, ROWS - 1, COLS - 1, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_PUT, tcce_pkg::NEWLINE_CHAR, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_MOVE, 8'h00, ROWS, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_MOVE, 8'h00, ROW_CODE_TOP, COL_CODE_TOP, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_WRITE, 8'hAA, 0, 5, 4'hF));
        queue_cmd(make_cmd(tcce_pkg::KIND_WRITE, 8'h55, ROWS, 5, 4'h3));
        queue_cmd(make_cmd(tcce_pkg::KIND_READ, 8'h00, 0, 5, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_READ, 8'h00, ROW_CODE_TOP, COL_CODE_TOP, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_MOVE, 8'h00, 0, COLS - 1, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_DELETE, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_MOVE, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_DELETE, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_CLEAR_LINE, 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(4'(KIND_CODE_TOP), 8'h00, 0, 0, 4'h0));
        queue_cmd(make_cmd(tcce_pkg::KIND_CLEAR_SCRN, 8'h00, 0, 0, 4'h0));

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle(SETTLE);
                @(posedge aclk);
                cfg_wr_en    <= 1'b1;
                cfg_wr_data  <= phase_color[phase];
                shadow_color = phase_color[phase];
                @(posedge aclk);
                cfg_wr_en    <= 1'b0;
            end
            count = 0;
            while (count < RANDOM_ITEMS / PHASES) begin
                c = random_cmd();
                queue_cmd(c);
                if (c.kind <= tcce_pkg::KIND_READ) count++;
            end
        end

        wait_idle(DRAIN);

        $display("Ran %0d commands over %0d text colors; %0d results checked, %0d mismatches.",
                 accepted, PHASES, checked, mismatches);
        $display("Covered cursor wraps and edges, deletes, clears, cell writes and reads, %0s",
                 "random gaps on both channels and a long result hold-off.");
        if (mismatches == 0 && cursor_report_q.size() == 0) begin
            $display("text_console_cursor_engine regression: pass");
        end else begin
            $display("text_console_cursor_engine regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/tcce_pkg.sv
sv/tcce_screen_ram.sv
sv/text_console_cursor_engine.sv
bench/tb.sv
